// ----- design/icsh_pkg.sv -----
// shared constants, types and command codes of the cell span histogram
package icsh_pkg;

  localparam int BIN_COUNT = 256;
  localparam int COUNT_WIDTH = 32;
  localparam int BIN_W = $clog2(BIN_COUNT);
  localparam int VAL_W = 8;
  localparam int CORNER_N = 8;
  localparam int CORNER_IDX_W = $clog2(CORNER_N);
  localparam int OUT_W = 32;
  // wide enough for any corner value and for the bin count itself
  localparam int CMP_W = ((BIN_W > VAL_W) ? BIN_W : VAL_W) + 1;
  localparam logic [CMP_W-1:0] BIN_LAST = CMP_W'(BIN_COUNT - 1);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MINMAX,
    S_WALK,
    S_READ,
    S_RDATA,
    S_OUT
  } state_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] lo;
    logic [VAL_W-1:0] hi;
  } mm_status_t;

endpackage

// ----- design/icsh_minmax.sv -----
// corner minimum and maximum, one corner per cycle through a shared compare pair
module icsh_minmax (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          start,
  input  logic [icsh_pkg::CORNER_N-1:0][icsh_pkg::VAL_W-1:0] corners,
  output icsh_pkg::mm_status_t                          status
);

  logic                                                 busy_r, busy_nxt;
  logic                                                 done_r, done_nxt;
  logic [icsh_pkg::CORNER_IDX_W-1:0]                    cnt_r, cnt_nxt;
  logic [icsh_pkg::CORNER_N-1:0][icsh_pkg::VAL_W-1:0]   sr_r, sr_nxt;
  logic [icsh_pkg::VAL_W-1:0]                           lo_r, lo_nxt;
  logic [icsh_pkg::VAL_W-1:0]                           hi_r, hi_nxt;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    sr_nxt   = sr_r;
    lo_nxt   = lo_r;
    hi_nxt   = hi_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      sr_nxt   = corners;
      lo_nxt   = '1;
      hi_nxt   = '0;
    end else if (busy_r) begin
      if (sr_r[0] < lo_r) lo_nxt = sr_r[0];
      if (sr_r[0] > hi_r) hi_nxt = sr_r[0];
      // shift the next corner into the compare slot
      sr_nxt = {icsh_pkg::VAL_W'(0), sr_r[icsh_pkg::CORNER_N-1:1]};
      cnt_nxt = cnt_r + icsh_pkg::CORNER_IDX_W'(1);
      if (cnt_r == icsh_pkg::CORNER_IDX_W'(icsh_pkg::CORNER_N - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sr_r <= sr_nxt;
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
  end

  assign status.done = done_r;
  assign status.lo   = lo_r;
  assign status.hi   = hi_r;

endmodule

// ----- design/isovalue_cell_span_histogram.sv -----
// top level of the isovalue cell span histogram
// Keeps BIN_COUNT saturating counters in one dual-port memory (one write, one registered read
// per cycle) and the running peak over bins 1 and up. After reset the block sweeps the memory
// to zero with in_stall high. A clear word takes the same sweep, then gives its result word.
// An add word first finds the corner minimum and maximum in icsh_minmax, then walks the span
// with an overlapped read-modify-write, each bin written back in the cycle after its registered read.
// A read word reads the selected bin from the registered memory port and returns its count.
// One word is in flight at a time; the next is taken once the result word has left.
module isovalue_cell_span_histogram (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_cmd,
  input  logic [icsh_pkg::VAL_W-1:0]  in_corner_a,
  input  logic [icsh_pkg::VAL_W-1:0]  in_corner_b,
  input  logic [icsh_pkg::VAL_W-1:0]  in_corner_c,
  input  logic [icsh_pkg::VAL_W-1:0]  in_corner_d,
  input  logic [icsh_pkg::VAL_W-1:0]  in_corner_e,
  input  logic [icsh_pkg::VAL_W-1:0]  in_corner_f,
  input  logic [icsh_pkg::VAL_W-1:0]  in_corner_g,
  input  logic [icsh_pkg::VAL_W-1:0]  in_corner_h,
  input  logic [icsh_pkg::VAL_W-1:0]  in_bin_select,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [icsh_pkg::OUT_W-1:0]  out_bin_count,
  output logic [icsh_pkg::OUT_W-1:0]  out_peak_count,
  output logic [icsh_pkg::VAL_W-1:0]  out_cell_low,
  output logic [icsh_pkg::VAL_W-1:0]  out_cell_high
);

  icsh_pkg::state_t                     state_r, state_nxt;
  logic [icsh_pkg::BIN_W-1:0]           clr_idx_r, clr_idx_nxt;
  logic                                 clr_report_r, clr_report_nxt;
  logic [icsh_pkg::CMP_W-1:0]           rd_idx_r, rd_idx_nxt;
  logic [icsh_pkg::CMP_W-1:0]           last_r, last_nxt;
  logic                                 rd_live_r, rd_live_nxt;
  logic [icsh_pkg::BIN_W-1:0]           wr_idx_r, wr_idx_nxt;
  logic [icsh_pkg::COUNT_WIDTH-1:0]     peak_r, peak_nxt;
  logic [icsh_pkg::VAL_W-1:0]           sel_r, sel_nxt;
  logic                                 out_valid_r, out_valid_nxt;
  logic [icsh_pkg::OUT_W-1:0]           out_bin_r, out_bin_nxt;
  logic [icsh_pkg::OUT_W-1:0]           out_peak_r, out_peak_nxt;
  logic [icsh_pkg::VAL_W-1:0]           out_low_r, out_low_nxt;
  logic [icsh_pkg::VAL_W-1:0]           out_high_r, out_high_nxt;

  logic [icsh_pkg::COUNT_WIDTH-1:0]     mem [icsh_pkg::BIN_COUNT];
  logic [icsh_pkg::COUNT_WIDTH-1:0]     rdata_r;
  logic                                 mem_we, mem_re;
  logic [icsh_pkg::BIN_W-1:0]           mem_waddr, mem_raddr;
  logic [icsh_pkg::COUNT_WIDTH-1:0]     mem_wdata;

  logic                                 in_accept;
  logic                                 mm_start;
  icsh_pkg::mm_status_t                 mm;
  logic [icsh_pkg::CMP_W-1:0]           hi_ext, sel_ext;
  logic [icsh_pkg::COUNT_WIDTH-1:0]     inc_val;
  logic                                 issue;

  assign in_stall  = (state_r != icsh_pkg::S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign mm_start  = in_accept && (in_cmd == icsh_pkg::CMD_ADD);

  icsh_minmax u_minmax (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mm_start),
    .corners ({in_corner_h, in_corner_g, in_corner_f, in_corner_e,
               in_corner_d, in_corner_c, in_corner_b, in_corner_a}),
    .status  (mm)
  );

  assign hi_ext  = icsh_pkg::CMP_W'(mm.hi);
  assign sel_ext = icsh_pkg::CMP_W'(sel_r);
  assign inc_val = (rdata_r == icsh_pkg::COUNT_MAX) ? rdata_r
                                                    : rdata_r + icsh_pkg::COUNT_WIDTH'(1);
  assign issue   = (rd_idx_r <= last_r);

  always_comb begin
    state_nxt      = state_r;
    clr_idx_nxt    = clr_idx_r;
    clr_report_nxt = clr_report_r;
    rd_idx_nxt     = rd_idx_r;
    last_nxt       = last_r;
    rd_live_nxt    = 1'b0;
    wr_idx_nxt     = wr_idx_r;
    peak_nxt       = peak_r;
    sel_nxt        = sel_r;
    out_valid_nxt  = out_valid_r;
    out_bin_nxt    = out_bin_r;
    out_peak_nxt   = out_peak_r;
    out_low_nxt    = out_low_r;
    out_high_nxt   = out_high_r;
    mem_we         = 1'b0;
    mem_waddr      = clr_idx_r;
    mem_wdata      = '0;
    mem_re         = 1'b0;
    mem_raddr      = rd_idx_r[icsh_pkg::BIN_W-1:0];

    case (state_r)
      icsh_pkg::S_CLEAR: begin
        mem_we   = 1'b1;
        peak_nxt = '0;
        clr_idx_nxt = clr_idx_r + icsh_pkg::BIN_W'(1);
        if (clr_idx_r == icsh_pkg::BIN_W'(icsh_pkg::BIN_COUNT - 1)) begin
          clr_idx_nxt = '0;
          if (clr_report_r) begin
            out_valid_nxt = 1'b1;
            out_bin_nxt   = '0;
            out_peak_nxt  = '0;
            out_low_nxt   = '0;
            out_high_nxt  = '0;
            state_nxt     = icsh_pkg::S_OUT;
          end else begin
            state_nxt = icsh_pkg::S_IDLE;
          end
        end
      end
      icsh_pkg::S_IDLE: begin
        if (in_accept) begin
          sel_nxt = in_bin_select;
          case (in_cmd)
            icsh_pkg::CMD_CLEAR: begin
              clr_idx_nxt    = '0;
              clr_report_nxt = 1'b1;
              state_nxt      = icsh_pkg::S_CLEAR;
            end
            icsh_pkg::CMD_ADD:  state_nxt = icsh_pkg::S_MINMAX;
            icsh_pkg::CMD_READ: state_nxt = icsh_pkg::S_READ;
            default: begin
              out_valid_nxt = 1'b1;
              out_bin_nxt   = '0;
              out_peak_nxt  = icsh_pkg::OUT_W'(peak_r);
              out_low_nxt   = '0;
              out_high_nxt  = '0;
              state_nxt     = icsh_pkg::S_OUT;
            end
          endcase
        end
      end
      icsh_pkg::S_MINMAX: begin
        if (mm.done) begin
          rd_idx_nxt = icsh_pkg::CMP_W'(mm.lo);
          last_nxt   = (hi_ext > icsh_pkg::BIN_LAST) ? icsh_pkg::BIN_LAST : hi_ext;
          state_nxt  = icsh_pkg::S_WALK;
        end
      end
      icsh_pkg::S_WALK: begin
        // read bin n+1 while bin n is written back
        if (issue) begin
          mem_re      = 1'b1;
          rd_live_nxt = 1'b1;
          wr_idx_nxt  = rd_idx_r[icsh_pkg::BIN_W-1:0];
          rd_idx_nxt  = rd_idx_r + icsh_pkg::CMP_W'(1);
        end
        if (rd_live_r) begin
          mem_we    = 1'b1;
          mem_waddr = wr_idx_r;
          mem_wdata = inc_val;
          if ((wr_idx_r != '0) && (inc_val > peak_r)) peak_nxt = inc_val;
        end
        if (!issue && !rd_live_r) begin
          out_valid_nxt = 1'b1;
          out_bin_nxt   = '0;
          out_peak_nxt  = icsh_pkg::OUT_W'(peak_r);
          out_low_nxt   = mm.lo;
          out_high_nxt  = mm.hi;
          state_nxt     = icsh_pkg::S_OUT;
        end
      end
      icsh_pkg::S_READ: begin
        mem_re    = 1'b1;
        mem_raddr = sel_ext[icsh_pkg::BIN_W-1:0];
        state_nxt = icsh_pkg::S_RDATA;
      end
      icsh_pkg::S_RDATA: begin
        out_valid_nxt = 1'b1;
        out_bin_nxt   = (sel_ext <= icsh_pkg::BIN_LAST) ? icsh_pkg::OUT_W'(rdata_r) : '0;
        out_peak_nxt  = icsh_pkg::OUT_W'(peak_r);
        out_low_nxt   = '0;
        out_high_nxt  = '0;
        state_nxt     = icsh_pkg::S_OUT;
      end
      icsh_pkg::S_OUT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          state_nxt     = icsh_pkg::S_IDLE;
        end
      end
      default: state_nxt = icsh_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= icsh_pkg::S_CLEAR;
      clr_idx_r    <= '0;
      clr_report_r <= 1'b0;
      rd_live_r    <= 1'b0;
      peak_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_idx_r    <= clr_idx_nxt;
      clr_report_r <= clr_report_nxt;
      rd_live_r    <= rd_live_nxt;
      peak_r       <= peak_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r   <= rd_idx_nxt;
    last_r     <= last_nxt;
    wr_idx_r   <= wr_idx_nxt;
    sel_r      <= sel_nxt;
    out_bin_r  <= out_bin_nxt;
    out_peak_r <= out_peak_nxt;
    out_low_r  <= out_low_nxt;
    out_high_r <= out_high_nxt;
  end

  // counter store
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_r <= mem[mem_raddr];
  end

  assign out_valid      = out_valid_r;
  assign out_bin_count  = out_bin_r;
  assign out_peak_count = out_peak_r;
  assign out_cell_low   = out_low_r;
  assign out_cell_high  = out_high_r;

  a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> in_stall)
    else $error("input taken while a result word is pending");

  a_peak_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != icsh_pkg::S_CLEAR) |=> (peak_r >= $past(peak_r)))
    else $error("peak dropped outside a clear");

  a_span_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_low_r <= out_high_r))
    else $error("cell low above cell high");

  a_live_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    rd_live_r |-> (state_r == icsh_pkg::S_WALK))
    else $error("write-back pending outside the span walk");

  a_mm_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    mm.done |-> (state_r == icsh_pkg::S_MINMAX))
    else $error("corner unit finished outside its wait state");

endmodule

// ----- tb/isovalue_cell_span_histogram_tb.sv -----
// self-checking testbench for the isovalue cell span histogram, directed table then random words
`timescale 1ns / 1ps

module isovalue_cell_span_histogram_tb;

  localparam int RANDOM_WORDS = 628;
  localparam int PAUSE_AT = 300;
  localparam int QUIET_WORDS = 100;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 300;
  localparam int DIR_ROWS = 22;
  localparam int MAX_PRINTS = 40;

  typedef struct packed {
    icsh_pkg::cmd_t                                      cmd;
    logic [icsh_pkg::CORNER_N-1:0][icsh_pkg::VAL_W-1:0]  corner;
    logic [icsh_pkg::VAL_W-1:0]                          sel;
  } hist_word_t;

  typedef struct packed {
    logic [icsh_pkg::OUT_W-1:0] bin;
    logic [icsh_pkg::OUT_W-1:0] peak;
    logic [icsh_pkg::VAL_W-1:0] lo;
    logic [icsh_pkg::VAL_W-1:0] hi;
  } hist_result_t;

  typedef struct packed {
    hist_word_t   word;
    logic         typed;
    hist_result_t result;
  } dir_row_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_cmd = 2'd0;
  logic [icsh_pkg::VAL_W-1:0] in_corner_a = '0;
  logic [icsh_pkg::VAL_W-1:0] in_corner_b = '0;
  logic [icsh_pkg::VAL_W-1:0] in_corner_c = '0;
  logic [icsh_pkg::VAL_W-1:0] in_corner_d = '0;
  logic [icsh_pkg::VAL_W-1:0] in_corner_e = '0;
  logic [icsh_pkg::VAL_W-1:0] in_corner_f = '0;
  logic [icsh_pkg::VAL_W-1:0] in_corner_g = '0;
  logic [icsh_pkg::VAL_W-1:0] in_corner_h = '0;
  logic [icsh_pkg::VAL_W-1:0] in_bin_select = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [icsh_pkg::OUT_W-1:0] out_bin_count;
  logic [icsh_pkg::OUT_W-1:0] out_peak_count;
  logic [icsh_pkg::VAL_W-1:0] out_cell_low;
  logic [icsh_pkg::VAL_W-1:0] out_cell_high;

  // predicted histogram state
  logic [icsh_pkg::COUNT_WIDTH-1:0] span_count_q [icsh_pkg::BIN_COUNT];
  logic [icsh_pkg::COUNT_WIDTH-1:0] peak_q;

  hist_result_t pending_results[$];
  dir_row_t dir_table [DIR_ROWS];
  int mismatch_count = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;

  isovalue_cell_span_histogram u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_corner_a    (in_corner_a),
    .in_corner_b    (in_corner_b),
    .in_corner_c    (in_corner_c),
    .in_corner_d    (in_corner_d),
    .in_corner_e    (in_corner_e),
    .in_corner_f    (in_corner_f),
    .in_corner_g    (in_corner_g),
    .in_corner_h    (in_corner_h),
    .in_bin_select  (in_bin_select),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_bin_count  (out_bin_count),
    .out_peak_count (out_peak_count),
    .out_cell_low   (out_cell_low),
    .out_cell_high  (out_cell_high)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic note_mismatch(input string what, input logic [icsh_pkg::OUT_W-1:0] got,
                               input logic [icsh_pkg::OUT_W-1:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS)
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
  endtask

  // applies one word to the predicted histogram and returns its result word
  function automatic hist_result_t predict_span_update(input hist_word_t w);
    hist_result_t r;
    logic [icsh_pkg::VAL_W-1:0] lo;
    logic [icsh_pkg::VAL_W-1:0] hi;
    int m;
    r = '0;
    case (w.cmd)
      icsh_pkg::CMD_CLEAR: begin
        for (m = 0; m < icsh_pkg::BIN_COUNT; m++) span_count_q[m] = '0;
        peak_q = '0;
      end
      icsh_pkg::CMD_ADD: begin
        lo = '1;
        hi = '0;
        for (m = 0; m < icsh_pkg::CORNER_N; m++) begin
          if (w.corner[m] < lo) lo = w.corner[m];
          if (w.corner[m] > hi) hi = w.corner[m];
        end
        for (m = int'(lo); m <= int'(hi); m++) begin
          if (m >= icsh_pkg::BIN_COUNT) break;
          if (span_count_q[m] != icsh_pkg::COUNT_MAX)
            span_count_q[m] = span_count_q[m] + 1'b1;
          // bin 0 never takes part in the peak
          if (m >= 1 && span_count_q[m] > peak_q) peak_q = span_count_q[m];
        end
        r.lo = lo;
        r.hi = hi;
      end
      icsh_pkg::CMD_READ: begin
        if (int'(w.sel) < icsh_pkg::BIN_COUNT)
          r.bin = icsh_pkg::OUT_W'(span_count_q[w.sel]);
      end
      default: ;
    endcase
    r.peak = icsh_pkg::OUT_W'(peak_q);
    return r;
  endfunction

  function automatic int near_value(input int base, input int spread);
    int v;
    v = base + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v;
  endfunction

  function automatic hist_word_t random_word();
    hist_word_t w;
    int pick;
    int mode;
    int base;
    int spread;
    int k;
    w.sel = icsh_pkg::VAL_W'($urandom);
    for (k = 0; k < icsh_pkg::CORNER_N; k++) w.corner[k] = icsh_pkg::VAL_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 3) w.cmd = icsh_pkg::CMD_CLEAR;
    else if (pick < 6) w.cmd = icsh_pkg::CMD_NONE;
    else if (pick < 55) w.cmd = icsh_pkg::CMD_ADD;
    else w.cmd = icsh_pkg::CMD_READ;
    if (w.cmd == icsh_pkg::CMD_ADD) begin
      mode = $urandom_range(0, 3);
      base = $urandom_range(0, 255);
      spread = $urandom_range(0, 40);
      for (k = 0; k < icsh_pkg::CORNER_N; k++) begin
        case (mode)
          0: w.corner[k] = icsh_pkg::VAL_W'($urandom);
          1: w.corner[k] = icsh_pkg::VAL_W'(near_value(base, spread));
          2: w.corner[k] = icsh_pkg::VAL_W'(base);
          default: begin
            case ($urandom_range(0, 2))
              0: w.corner[k] = '0;
              1: w.corner[k] = '1;
              default: w.corner[k] = icsh_pkg::VAL_W'(near_value(base, spread));
            endcase
          end
        endcase
      end
    end else if (w.cmd == icsh_pkg::CMD_READ && $urandom_range(0, 7) == 0) begin
      w.sel = $urandom_range(0, 1) ? '1 : '0;
    end
    return w;
  endfunction

  function automatic dir_row_t dir_entry(input icsh_pkg::cmd_t c, input logic [63:0] corners,
                                         input logic [icsh_pkg::VAL_W-1:0] sel,
                                         input logic typed,
                                         input logic [icsh_pkg::OUT_W-1:0] bin,
                                         input logic [icsh_pkg::OUT_W-1:0] peak,
                                         input logic [icsh_pkg::VAL_W-1:0] lo,
                                         input logic [icsh_pkg::VAL_W-1:0] hi);
    dir_row_t row;
    row.word.cmd = c;
    row.word.corner = corners;
    row.word.sel = sel;
    row.typed = typed;
    row.result = {bin, peak, lo, hi};
    return row;
  endfunction

  // holds the word until the block takes it; in_valid stays high afterward
  task automatic send_word(input hist_word_t w);
    in_valid <= 1'b1;
    in_cmd <= w.cmd;
    in_corner_a <= w.corner[0];
    in_corner_b <= w.corner[1];
    in_corner_c <= w.corner[2];
    in_corner_d <= w.corner[3];
    in_corner_e <= w.corner[4];
    in_corner_f <= w.corner[5];
    in_corner_g <= w.corner[6];
    in_corner_h <= w.corner[7];
    in_bin_select <= w.sel;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic sender_gap();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 10)) @(posedge clk);
  endtask

  // receiver stall bursts
  initial begin
    int n;
    @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 10);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        @(posedge clk);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    hist_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        note_mismatch("result word with nothing pending", out_bin_count, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_bin_count !== want.bin) note_mismatch("bin_count", out_bin_count, want.bin);
        if (out_peak_count !== want.peak)
          note_mismatch("peak_count", out_peak_count, want.peak);
        if (out_cell_low !== want.lo)
          note_mismatch("cell_low", icsh_pkg::OUT_W'(out_cell_low), icsh_pkg::OUT_W'(want.lo));
        if (out_cell_high !== want.hi)
          note_mismatch("cell_high", icsh_pkg::OUT_W'(out_cell_high),
                        icsh_pkg::OUT_W'(want.hi));
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    hist_word_t w;
    hist_result_t r;
    int i;
    for (i = 0; i < icsh_pkg::BIN_COUNT; i++) span_count_q[i] = '0;
    peak_q = '0;

    // after reset, extremes, unused command
    dir_table[0]  = dir_entry(icsh_pkg::CMD_READ,  64'h0, 8'h00, 1'b1, 0, 0, 8'h00, 8'h00);
    dir_table[1]  = dir_entry(icsh_pkg::CMD_READ,  64'h0, 8'hFF, 1'b1, 0, 0, 8'h00, 8'h00);
    dir_table[2]  = dir_entry(icsh_pkg::CMD_NONE,  64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 1'b1,
                              0, 0, 8'h00, 8'h00);
    dir_table[3]  = dir_entry(icsh_pkg::CMD_ADD,   64'h0, 8'h00, 1'b1, 0, 0, 8'h00, 8'h00);
    dir_table[4]  = dir_entry(icsh_pkg::CMD_ADD,   64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b1,
                              0, 1, 8'hFF, 8'hFF);
    dir_table[5]  = dir_entry(icsh_pkg::CMD_ADD,   64'h00FF_00FF_00FF_00FF, 8'h00, 1'b1,
                              0, 2, 8'h00, 8'hFF);
    dir_table[6]  = dir_entry(icsh_pkg::CMD_READ,  64'h0, 8'hFF, 1'b1, 2, 2, 8'h00, 8'h00);
    dir_table[7]  = dir_entry(icsh_pkg::CMD_READ,  64'h0, 8'h00, 1'b1, 2, 2, 8'h00, 8'h00);
    dir_table[8]  = dir_entry(icsh_pkg::CMD_READ,  64'h0, 8'h80, 1'b1, 1, 2, 8'h00, 8'h00);
    // min and max on different corners, then all corners equal, then a clear
    dir_table[9]  = dir_entry(icsh_pkg::CMD_ADD,   64'h8081_8283_8485_8607, 8'h00, 1'b0,
                              0, 0, 8'h00, 8'h00);
    dir_table[10] = dir_entry(icsh_pkg::CMD_ADD,   64'h1090_9090_9090_9090, 8'h00, 1'b0,
                              0, 0, 8'h00, 8'h00);
    dir_table[11] = dir_entry(icsh_pkg::CMD_ADD,   64'hAA55_AA55_AA55_AA55, 8'h00, 1'b0,
                              0, 0, 8'h00, 8'h00);
    dir_table[12] = dir_entry(icsh_pkg::CMD_ADD,   64'h2021_22F0_2324_2526, 8'h00, 1'b0,
                              0, 0, 8'h00, 8'h00);
    dir_table[13] = dir_entry(icsh_pkg::CMD_ADD,   64'h0101_0101_0101_0101, 8'h00, 1'b0,
                              0, 0, 8'h00, 8'h00);
    dir_table[14] = dir_entry(icsh_pkg::CMD_READ,  64'h0, 8'h01, 1'b0, 0, 0, 8'h00, 8'h00);
    dir_table[15] = dir_entry(icsh_pkg::CMD_READ,  64'h0, 8'hAA, 1'b0, 0, 0, 8'h00, 8'h00);
    dir_table[16] = dir_entry(icsh_pkg::CMD_NONE,  64'h1234_5678_9ABC_DEF0, 8'h55, 1'b0,
                              0, 0, 8'h00, 8'h00);
    dir_table[17] = dir_entry(icsh_pkg::CMD_CLEAR, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 1'b1,
                              0, 0, 8'h00, 8'h00);
    dir_table[18] = dir_entry(icsh_pkg::CMD_READ,  64'h0, 8'hFF, 1'b1, 0, 0, 8'h00, 8'h00);
    dir_table[19] = dir_entry(icsh_pkg::CMD_READ,  64'h0, 8'h00, 1'b1, 0, 0, 8'h00, 8'h00);
    dir_table[20] = dir_entry(icsh_pkg::CMD_ADD,   64'h0000_0000_0000_00FE, 8'h00, 1'b1,
                              0, 1, 8'h00, 8'hFE);
    dir_table[21] = dir_entry(icsh_pkg::CMD_READ,  64'h0, 8'hFF, 1'b1, 0, 1, 8'h00, 8'h00);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < DIR_ROWS; i++) begin
      if ($urandom_range(0, 3) == 0) sender_gap();
      send_word(dir_table[i].word);
      r = predict_span_update(dir_table[i].word);
      pending_results.push_back(dir_table[i].typed ? dir_table[i].result : r);
    end

    for (i = 0; i < RANDOM_WORDS; i++) begin
      if (i >= RANDOM_WORDS - QUIET_WORDS) quiet = 1'b1;
      if (!quiet && $urandom_range(0, 5) == 0) sender_gap();
      w = random_word();
      send_word(w);
      pending_results.push_back(predict_span_update(w));
      if (i == PAUSE_AT) begin
        // let the block drain completely before the next word
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      note_mismatch("results never returned", pending_results.size(), 0);

    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/icsh_pkg.sv
design/icsh_minmax.sv
design/isovalue_cell_span_histogram.sv
tb/isovalue_cell_span_histogram_tb.sv
